// File: hw/rtl/two_finger_swipe_recognizer_core_defines.svh
// Assertion macros for the two-finger swipe recognizer.
// Included by RTL files that carry concurrent checks; expects clk and arst_n in scope.
`ifndef TWO_FINGER_SWIPE_RECOGNIZER_CORE_DEFINES_SVH
`define TWO_FINGER_SWIPE_RECOGNIZER_CORE_DEFINES_SVH

// Same-cycle implication.
`define TFSR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TFSR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/tfsr_pkg.sv
// Shared types, codes and helper functions for the two-finger swipe recognizer.
// No dependencies; imported by tfsr_step and the top level.
`default_nettype none

package tfsr_pkg;

	localparam int COORD_BITS = 16;
	localparam int POS_BITS   = 16;
	localparam int THR_BITS   = 16;
	localparam int CNT_BITS   = 4;
	localparam int CODE_BITS  = 3;
	localparam int OP_BITS    = 3;
	localparam int SLOT_BITS  = 4;
	localparam int ADDR_BITS  = 3;
	localparam int DATA_BITS  = 32;
	localparam int DELTA_BITS = COORD_BITS + 2;
	localparam int MAG_BITS   = COORD_BITS + 1;
	localparam int MAN_BITS   = (COORD_BITS + 2 > THR_BITS + 1) ? COORD_BITS + 2 : THR_BITS + 1;

	localparam logic [CNT_BITS-1:0] CNT_MAX   = '1;
	localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(320);

	typedef logic [CODE_BITS-1:0] code_t;

	localparam code_t ST_IGNORE    = 3'd0;
	localparam code_t ST_MAYBE     = 3'd1;
	localparam code_t ST_UPDATE    = 3'd2;
	localparam code_t ST_FINISHED  = 3'd3;
	localparam code_t ST_CANCELLED = 3'd4;

	localparam code_t DIR_NONE  = 3'd0;
	localparam code_t DIR_LEFT  = 3'd1;
	localparam code_t DIR_RIGHT = 3'd2;
	localparam code_t DIR_UP    = 3'd3;
	localparam code_t DIR_DOWN  = 3'd4;

	typedef enum logic [OP_BITS-1:0] {
		OP_DOWN,
		OP_MOTION,
		OP_UP,
		OP_FRAME,
		OP_CANCEL,
		OP_RESET
	} op_t;

	localparam logic [ADDR_BITS-1:0] ADDR_THRESHOLD = '0;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic signed [DELTA_BITS-1:0] delta_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} point_t;

	typedef struct packed {
		logic [CNT_BITS-1:0] cnt;
		logic                cancelled;
		logic                started;
		code_t               dir;
		point_t [1:0]        start;
		point_t [1:0]        last;
		point_t [1:0]        cur;
	} gest_state_t;

	// Difference of two coordinate sums (twice the centroid move).
	function automatic delta_t sum_delta(coord_t f0, coord_t f1, coord_t t0, coord_t t1);
		logic [DELTA_BITS-1:0] a;
		logic [DELTA_BITS-1:0] b;
		a = DELTA_BITS'(t0) + DELTA_BITS'(t1);
		b = DELTA_BITS'(f0) + DELTA_BITS'(f1);
		return delta_t'(a - b);
	endfunction

	function automatic logic [MAG_BITS-1:0] mag(delta_t d);
		logic [DELTA_BITS-1:0] m;
		m = d[DELTA_BITS-1] ? DELTA_BITS'(-d) : DELTA_BITS'(d);
		return m[MAG_BITS-1:0];
	endfunction

	function automatic logic reached(delta_t dx, delta_t dy, logic [THR_BITS-1:0] thr);
		logic [MAN_BITS-1:0] man;
		man = MAN_BITS'(mag(dx)) + MAN_BITS'(mag(dy));
		return man >= MAN_BITS'({thr, 1'b0});
	endfunction

	function automatic code_t pick_dir(delta_t dx, delta_t dy);
		logic dx_pos;
		logic dy_pos;
		dx_pos = !dx[DELTA_BITS-1] && (dx != '0);
		dy_pos = !dy[DELTA_BITS-1] && (dy != '0);
		if (mag(dx) > mag(dy)) begin
			return dx_pos ? DIR_RIGHT : DIR_LEFT;
		end
		return dy_pos ? DIR_DOWN : DIR_UP;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/two_finger_swipe_recognizer_core.sv
// Top level of the two-finger swipe recognizer: input register, gesture state,
// result register and threshold register. Depends on tfsr_pkg, tfsr_step, defines header.
//
// Usage:
// - Input channel (in_valid/in_stall) carries one touch item: op, slot, pos_x, pos_y.
// - Output channel (out_valid/out_stall) returns exactly one result item per input
//   item: status, last_direction, total_direction, in input order.
// - swipe_threshold sits at APB byte address 0; write it only while the block is idle.
// - Pipeline: an accepted item is registered in the input stage, and its result is
//   registered in the result register once that register is free, raising out_valid.
// - Throughput: one item per cycle unless the receiver stalls. The step logic reads and
//   rewrites the gesture state per item, so each item sees the state the previous one left.
// - When the receiver stalls, the result register holds; the input register still
//   takes one more item, after which in_stall goes high until the result drains.
// - Reset clears the gesture state, both valid flags and sets the threshold to 320.
`default_nettype none
`include "two_finger_swipe_recognizer_core_defines.svh"

module two_finger_swipe_recognizer_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [tfsr_pkg::OP_BITS-1:0]        op,
	input  logic [tfsr_pkg::SLOT_BITS-1:0]      slot,
	input  logic [tfsr_pkg::POS_BITS-1:0]       pos_x,
	input  logic [tfsr_pkg::POS_BITS-1:0]       pos_y,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [tfsr_pkg::CODE_BITS-1:0]      status,
	output logic [tfsr_pkg::CODE_BITS-1:0]      last_direction,
	output logic [tfsr_pkg::CODE_BITS-1:0]      total_direction,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [tfsr_pkg::ADDR_BITS-1:0]      paddr,
	input  logic [tfsr_pkg::DATA_BITS-1:0]      pwdata,
	output logic [tfsr_pkg::DATA_BITS-1:0]      prdata,
	output logic                                pready
);
	import tfsr_pkg::*;

	logic                  valid_s1;
	logic [OP_BITS-1:0]    op_s1;
	logic [SLOT_BITS-1:0]  slot_s1;
	coord_t                x_s1;
	coord_t                y_s1;

	logic                  valid_s2;
	code_t                 status_s2;
	code_t                 last_dir_s2;
	code_t                 total_dir_s2;

	gest_state_t           state_q;
	gest_state_t           state_nxt;
	logic [THR_BITS-1:0]   thr_q;
	code_t                 status_nxt;
	code_t                 total_nxt;

	logic                  out_free;
	logic                  advance;
	logic                  take;
	logic                  cfg_wr;

	assign out_free = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign take     = in_valid && !in_stall;

	tfsr_step u_step (
		.st        (state_q),
		.op        (op_s1),
		.slot      (slot_s1),
		.px        (x_s1),
		.py        (y_s1),
		.thr       (thr_q),
		.nxt       (state_nxt),
		.status    (status_nxt),
		.total_dir (total_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1   <= op;
			slot_s1 <= slot;
			x_s1    <= COORD_BITS'(pos_x);
			y_s1    <= COORD_BITS'(pos_y);
		end
		if (advance) begin
			status_s2    <= status_nxt;
			last_dir_s2  <= state_nxt.dir;
			total_dir_s2 <= total_nxt;
		end
	end

	assign out_valid       = valid_s2;
	assign status          = status_s2;
	assign last_direction  = last_dir_s2;
	assign total_direction = total_dir_s2;

	// Configuration port
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_wr && paddr[ADDR_BITS-1] == ADDR_THRESHOLD[ADDR_BITS-1]) begin
			thr_q <= pwdata[THR_BITS-1:0];
		end
	end

	assign prdata = (paddr[ADDR_BITS-1] == ADDR_THRESHOLD[ADDR_BITS-1]) ?
		DATA_BITS'(thr_q) : '0;

	`TFSR_ASSERT_NOW(a_stall_needs_full, in_stall, valid_s1 && valid_s2, "stall with free stage")
	`TFSR_ASSERT_NEXT(a_cancel_result, advance && op_t'(op_s1) == OP_CANCEL, valid_s2 && status_s2 == ST_CANCELLED, "cancel item did not report cancelled")
	`TFSR_ASSERT_NOW(a_update_has_dir, valid_s2 && status_s2 == ST_UPDATE, last_dir_s2 != DIR_NONE, "update without direction")
	`TFSR_ASSERT_NOW(a_finish_has_dir, valid_s2 && status_s2 == ST_FINISHED, last_dir_s2 != DIR_NONE && state_q.cnt == '0, "finish without direction or with fingers down")

endmodule

`default_nettype wire

// File: hw/rtl/tfsr_step.sv
// Next-state and result logic for one touch item of the swipe recognizer.
// Purely combinational; depends on tfsr_pkg.
`default_nettype none

module tfsr_step (
	input  tfsr_pkg::gest_state_t             st,
	input  logic [tfsr_pkg::OP_BITS-1:0]      op,
	input  logic [tfsr_pkg::SLOT_BITS-1:0]    slot,
	input  tfsr_pkg::coord_t                  px,
	input  tfsr_pkg::coord_t                  py,
	input  logic [tfsr_pkg::THR_BITS-1:0]     thr,
	output tfsr_pkg::gest_state_t             nxt,
	output tfsr_pkg::code_t                   status,
	output tfsr_pkg::code_t                   total_dir
);
	import tfsr_pkg::*;

	logic [CNT_BITS-1:0] cnt_up;
	logic [CNT_BITS-1:0] cnt_dn;
	logic                slot_ok;
	logic                idx;
	point_t              pt;
	delta_t              fdx, fdy;
	logic                frame_hit;
	code_t               frame_dir;
	delta_t              tdx, tdy;

	assign cnt_up  = (st.cnt < CNT_MAX) ? st.cnt + 1'b1 : st.cnt;
	assign cnt_dn  = (st.cnt != '0) ? st.cnt - 1'b1 : st.cnt;
	assign slot_ok = (slot[SLOT_BITS-1:1] == '0);
	assign idx     = slot[0];
	assign pt      = '{x: px, y: py};

	assign fdx       = sum_delta(st.last[0].x, st.last[1].x, st.cur[0].x, st.cur[1].x);
	assign fdy       = sum_delta(st.last[0].y, st.last[1].y, st.cur[0].y, st.cur[1].y);
	assign frame_hit = reached(fdx, fdy, thr);
	assign frame_dir = pick_dir(fdx, fdy);

	always_comb begin
		nxt    = st;
		status = ST_IGNORE;
		unique case (op_t'(op))
			OP_DOWN: begin
				nxt.cnt = cnt_up;
				if (!st.cancelled) begin
					if (cnt_up <= CNT_BITS'(2) && slot_ok) begin
						nxt.start[idx] = pt;
					end
					if (cnt_up == CNT_BITS'(2)) begin
						nxt.started = 1'b1;
						nxt.last    = nxt.start;
						nxt.cur     = nxt.start;
						status      = ST_MAYBE;
					end else if (cnt_up > CNT_BITS'(2)) begin
						nxt.cancelled = 1'b1;
						status        = ST_CANCELLED;
					end
				end
			end
			OP_MOTION: begin
				if (!st.cancelled && slot_ok) begin
					nxt.cur[idx] = pt;
					if (!st.started) begin
						nxt.start[idx] = pt;
					end
				end
			end
			OP_UP: begin
				nxt.cnt = cnt_dn;
				if (cnt_dn == '0) begin
					if (!st.cancelled && st.started && st.dir != DIR_NONE) begin
						status = ST_FINISHED;
					end else begin
						nxt.cancelled = 1'b0;
						nxt.started   = 1'b0;
						nxt.dir       = DIR_NONE;
						nxt.start     = '0;
						nxt.last      = '0;
						nxt.cur       = '0;
					end
				end
			end
			OP_FRAME: begin
				if (!st.cancelled && st.started && st.cnt == CNT_BITS'(2) && frame_hit) begin
					nxt.last = st.cur;
					nxt.dir  = frame_dir;
					status   = ST_UPDATE;
				end
			end
			OP_CANCEL: begin
				nxt.cancelled = 1'b1;
				status        = ST_CANCELLED;
			end
			OP_RESET: begin
				nxt.cancelled = 1'b0;
				nxt.started   = 1'b0;
				nxt.dir       = DIR_NONE;
				nxt.start     = '0;
				nxt.last      = '0;
				nxt.cur       = '0;
			end
			default: begin
				nxt = st;
			end
		endcase
	end

	// Start-to-current direction, taken from the updated points.
	assign tdx       = sum_delta(nxt.start[0].x, nxt.start[1].x, nxt.cur[0].x, nxt.cur[1].x);
	assign tdy       = sum_delta(nxt.start[0].y, nxt.start[1].y, nxt.cur[0].y, nxt.cur[1].y);
	assign total_dir = reached(tdx, tdy, thr) ? pick_dir(tdx, tdy) : DIR_NONE;

endmodule

`default_nettype wire

// File: bench/two_finger_swipe_recognizer_core_tb.sv
// Self-checking bench for two_finger_swipe_recognizer_core: touch items in, one verdict per item out.
// Uses tfsr_pkg and the core; an in-bench gesture tracker predicts every verdict.
`timescale 1ns / 1ps

module testbench;
	import tfsr_pkg::*;

	localparam logic [OP_BITS-1:0] OP_SPARE_A = 3'd6;
	localparam logic [OP_BITS-1:0] OP_SPARE_B = 3'd7;
	localparam int POS_MAX = 65535;

	typedef struct packed {
		code_t status;
		code_t last_dir;
		code_t total_dir;
	} verdict_t;

	class swipe_tracker;
		logic [THR_BITS-1:0] thr;
		int fingers;
		bit cancelled;
		bit started;
		code_t dir;
		int sx[2], sy[2], lx[2], ly[2], cx[2], cy[2];
		verdict_t awaited[$];
		int mismatches;

		function new();
			thr = THR_RESET;
			fingers = 0;
			mismatches = 0;
			clear_gesture();
		endfunction

		function void clear_gesture();
			cancelled = 0;
			started = 0;
			dir = DIR_NONE;
			for (int i = 0; i < 2; i++) begin
				sx[i] = 0; sy[i] = 0; lx[i] = 0; ly[i] = 0; cx[i] = 0; cy[i] = 0;
			end
		endfunction

		function int iabs(int v);
			return v < 0 ? -v : v;
		endfunction

		function code_t choose_dir(int dx, int dy);
			if (iabs(dx) > iabs(dy))
				return dx > 0 ? DIR_RIGHT : DIR_LEFT;
			return dy > 0 ? DIR_DOWN : DIR_UP;
		endfunction

		function void flag(string what);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s", $time, what);
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function void note_event(logic [OP_BITS-1:0] code, logic [SLOT_BITS-1:0] s,
				coord_t x, coord_t y);
			verdict_t v;
			int dx, dy;
			v.status = ST_IGNORE;
			case (code)
				OP_DOWN: begin
					if (fingers < 15)
						fingers++;
					if (!cancelled) begin
						if (fingers <= 2 && s <= 1) begin
							sx[s] = int'(x);
							sy[s] = int'(y);
						end
						if (fingers == 2) begin
							started = 1;
							for (int i = 0; i < 2; i++) begin
								lx[i] = sx[i]; cx[i] = sx[i];
								ly[i] = sy[i]; cy[i] = sy[i];
							end
							v.status = ST_MAYBE;
						end else if (fingers > 2) begin
							cancelled = 1;
							v.status = ST_CANCELLED;
						end
					end
				end
				OP_MOTION: begin
					if (!cancelled && s <= 1) begin
						cx[s] = int'(x);
						cy[s] = int'(y);
						if (!started) begin
							sx[s] = int'(x);
							sy[s] = int'(y);
						end
					end
				end
				OP_UP: begin
					if (fingers > 0)
						fingers--;
					if (fingers == 0) begin
						if (!cancelled && started && dir != DIR_NONE)
							v.status = ST_FINISHED;
						else
							clear_gesture();
					end
				end
				OP_FRAME: begin
					if (!cancelled && started && fingers == 2) begin
						dx = (cx[0] + cx[1]) - (lx[0] + lx[1]);
						dy = (cy[0] + cy[1]) - (ly[0] + ly[1]);
						if (iabs(dx) + iabs(dy) >= 2 * int'(thr)) begin
							for (int i = 0; i < 2; i++) begin
								lx[i] = cx[i];
								ly[i] = cy[i];
							end
							dir = choose_dir(dx, dy);
							v.status = ST_UPDATE;
						end
					end
				end
				OP_CANCEL: begin
					cancelled = 1;
					v.status = ST_CANCELLED;
				end
				OP_RESET: clear_gesture();
				default: ;
			endcase
			v.last_dir = dir;
			dx = (cx[0] + cx[1]) - (sx[0] + sx[1]);
			dy = (cy[0] + cy[1]) - (sy[0] + sy[1]);
			v.total_dir = (iabs(dx) + iabs(dy) < 2 * int'(thr)) ? DIR_NONE : choose_dir(dx, dy);
			awaited.push_back(v);
		endfunction

		function void check_verdict(code_t st, code_t ld, code_t td);
			verdict_t exp_v;
			verdict_t got;
			got = {st, ld, td};
			if (awaited.size() == 0) begin
				flag($sformatf("verdict %0d/%0d/%0d with no item outstanding", st, ld, td));
				return;
			end
			exp_v = awaited.pop_front();
			if (got !== exp_v)
				flag($sformatf("status/last/total expected %0d/%0d/%0d got %0d/%0d/%0d",
					exp_v.status, exp_v.last_dir, exp_v.total_dir, st, ld, td));
		endfunction
	endclass

	logic clk = 0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [OP_BITS-1:0] op;
	logic [SLOT_BITS-1:0] slot;
	logic [POS_BITS-1:0] pos_x;
	logic [POS_BITS-1:0] pos_y;
	logic out_valid;
	logic out_stall;
	code_t status;
	code_t last_direction;
	code_t total_direction;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [DATA_BITS-1:0] pwdata;
	logic [DATA_BITS-1:0] prdata;
	logic pready;

	swipe_tracker tracker = new();
	int items_sent = 0;
	bit calm = 0;
	int stall_run = 0;

	two_finger_swipe_recognizer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.slot(slot),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.last_direction(last_direction),
		.total_direction(total_direction),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_verdict(status, last_direction, total_direction);
	end

	// receiver backpressure: mostly short bursts, occasionally long
	initial begin
		out_stall = 0;
		forever begin
			@(negedge clk);
			if (calm) begin
				out_stall = 0;
				stall_run = 0;
			end else if (stall_run > 0) begin
				stall_run--;
			end else begin
				case ($urandom_range(0, 99)) inside
					[0:59]: begin out_stall = 0; stall_run = $urandom_range(0, 6); end
					[60:92]: begin out_stall = 1; stall_run = $urandom_range(0, 3); end
					default: begin out_stall = 1; stall_run = $urandom_range(8, 40); end
				endcase
			end
		end
	end

	initial begin
		#20_000_000;
		$display("two_finger_swipe_recognizer_core regression: fail");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return coord_t'($urandom_range(0, POS_MAX));
		endcase
	endfunction

	function automatic int clamp_pos(int v);
		return v < 0 ? 0 : (v > POS_MAX ? POS_MAX : v);
	endfunction

	task automatic send_event(logic [OP_BITS-1:0] code, logic [SLOT_BITS-1:0] s,
			coord_t x, coord_t y);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1;
		op = code;
		slot = s;
		pos_x = x;
		pos_y = y;
		do @(posedge clk); while (in_stall);
		tracker.note_event(code, s, x, y);
		items_sent++;
	endtask

	task automatic write_threshold(logic [THR_BITS-1:0] value);
		@(negedge clk);
		in_valid = 0;
		while (tracker.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		psel = 1;
		pwrite = 1;
		penable = 0;
		paddr = ADDR_THRESHOLD;
		pwdata = DATA_BITS'(value);
		@(negedge clk);
		penable = 1;
		do @(posedge clk); while (!pready);
		tracker.thr = value;
		@(negedge clk);
		psel = 0;
		penable = 0;
		pwrite = 0;
	endtask

	task automatic rand_slot_event(logic [OP_BITS-1:0] code);
		send_event(code, SLOT_BITS'($urandom_range(0, 15)), rand_coord(), rand_coord());
	endtask

	// well-formed two-finger swipe with random content and the odd disruption
	task automatic swipe_gesture();
		int px[2], py[2];
		int vx, vy, span, first;
		while (tracker.fingers > 0) rand_slot_event(OP_UP);
		span = int'(tracker.thr) / 2 + 24;
		for (int f = 0; f < 2; f++) begin
			px[f] = int'(rand_coord());
			py[f] = int'(rand_coord());
		end
		if ($urandom_range(0, 1)) begin
			vx = $urandom_range(0, span);
			vy = $urandom_range(0, span / 4);
		end else begin
			vx = $urandom_range(0, span / 4);
			vy = $urandom_range(0, span);
		end
		if ($urandom_range(0, 1)) vx = -vx;
		if ($urandom_range(0, 1)) vy = -vy;
		first = $urandom_range(0, 1);
		send_event(OP_DOWN, SLOT_BITS'(first), coord_t'(px[first]), coord_t'(py[first]));
		if ($urandom_range(0, 2) == 0) begin
			px[first] = clamp_pos(px[first] + vx);
			py[first] = clamp_pos(py[first] + vy);
			send_event(OP_MOTION, SLOT_BITS'(first), coord_t'(px[first]), coord_t'(py[first]));
		end
		send_event(OP_DOWN, SLOT_BITS'(1 - first), coord_t'(px[1 - first]),
			coord_t'(py[1 - first]));
		repeat ($urandom_range(1, 10)) begin
			for (int f = 0; f < 2; f++) begin
				if ($urandom_range(0, 5) != 0) begin
					px[f] = clamp_pos(px[f] + vx + int'($urandom_range(0, 16)) - 8);
					py[f] = clamp_pos(py[f] + vy + int'($urandom_range(0, 16)) - 8);
					send_event(OP_MOTION, SLOT_BITS'(f), coord_t'(px[f]), coord_t'(py[f]));
				end
			end
			if ($urandom_range(0, 24) == 0) begin
				case ($urandom_range(0, 5))
					0: rand_slot_event(OP_CANCEL);
					1: rand_slot_event(OP_DOWN);
					2: rand_slot_event(OP_RESET);
					3: rand_slot_event($urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B);
					4: send_event(OP_MOTION, SLOT_BITS'($urandom_range(2, 15)),
						rand_coord(), rand_coord());
					default: rand_slot_event(OP_UP);
				endcase
			end
			rand_slot_event(OP_FRAME);
		end
		rand_slot_event(OP_UP);
		if ($urandom_range(0, 9) == 0)
			rand_slot_event(OP_FRAME);
		rand_slot_event(OP_UP);
	endtask

	initial begin
		int goal, k, n;
		arst_n = 0;
		in_valid = 0;
		op = OP_DOWN;
		slot = '0;
		pos_x = '0;
		pos_y = '0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		repeat (9) @(negedge clk);
		arst_n = 1;

		// directed: idle ops, full-range swipe in three directions, cancel paths
		send_event(OP_FRAME, 4'd0, 16'd0, 16'd0);
		send_event(OP_UP, 4'd0, 16'd0, 16'd0);
		send_event(OP_SPARE_A, 4'd15, 16'hFFFF, 16'hFFFF);
		send_event(OP_SPARE_B, 4'd15, 16'hFFFF, 16'hFFFF);
		send_event(OP_DOWN, 4'd0, 16'd0, 16'd0);
		send_event(OP_MOTION, 4'd0, 16'd10, 16'd20);
		send_event(OP_DOWN, 4'd1, 16'hFFFF, 16'hFFFF);
		send_event(OP_MOTION, 4'd0, 16'hFFFF, 16'd0);
		send_event(OP_FRAME, 4'd0, 16'd0, 16'd0);
		send_event(OP_MOTION, 4'd0, 16'd0, 16'd0);
		send_event(OP_MOTION, 4'd1, 16'd0, 16'd0);
		send_event(OP_FRAME, 4'd1, 16'd0, 16'd0);
		send_event(OP_MOTION, 4'd0, 16'd0, 16'hFFFF);
		send_event(OP_MOTION, 4'd1, 16'd0, 16'hFFFF);
		send_event(OP_FRAME, 4'd0, 16'd0, 16'd0);
		send_event(OP_MOTION, 4'd15, 16'd5, 16'd5);
		send_event(OP_FRAME, 4'd0, 16'd0, 16'd0);
		send_event(OP_UP, 4'd0, 16'd0, 16'd0);
		send_event(OP_UP, 4'd1, 16'd0, 16'd0);
		send_event(OP_DOWN, 4'd2, 16'h1234, 16'h4321);
		send_event(OP_DOWN, 4'd0, 16'd100, 16'd100);
		send_event(OP_DOWN, 4'd1, 16'd200, 16'd200);
		send_event(OP_MOTION, 4'd0, 16'd900, 16'd900);
		send_event(OP_DOWN, 4'd1, 16'd0, 16'd0);
		send_event(OP_CANCEL, 4'd0, 16'd0, 16'd0);
		send_event(OP_RESET, 4'd0, 16'd0, 16'd0);

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				1: write_threshold('0);
				2: write_threshold('1);
				3: write_threshold(THR_BITS'(1));
				4: write_threshold(THR_BITS'($urandom_range(16, 2000)));
				5: write_threshold(THR_RESET);
				default: ;
			endcase
			goal = items_sent + 285;
			while (items_sent < goal) begin
				calm = ($urandom_range(0, 4) == 0);
				k = $urandom_range(0, 99);
				if (k < 78) begin
					swipe_gesture();
				end else if (k < 92) begin
					repeat ($urandom_range(1, 8))
						send_event(OP_BITS'($urandom_range(0, 7)), SLOT_BITS'($urandom_range(0, 15)),
							rand_coord(), rand_coord());
				end else begin
					// pile of fingers to drive the count into saturation and back
					n = $urandom_range(13, 18);
					repeat (n) rand_slot_event(OP_DOWN);
					repeat (n + 1) rand_slot_event(OP_UP);
				end
			end
		end
		calm = 0;

		@(negedge clk);
		in_valid = 0;
		for (k = 0; k < 20000 && tracker.pending() != 0; k++) @(negedge clk);
		repeat (8) @(negedge clk);
		if (tracker.pending() != 0)
			tracker.flag($sformatf("%0d verdicts never arrived", tracker.pending()));
		if (tracker.mismatches == 0)
			$display("two_finger_swipe_recognizer_core regression: pass");
		else
			$display("two_finger_swipe_recognizer_core regression: fail");
		$finish;
	end
endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/tfsr_pkg.sv
hw/rtl/tfsr_step.sv
hw/rtl/two_finger_swipe_recognizer_core.sv
bench/two_finger_swipe_recognizer_core_tb.sv
